/* src/bqdp_pkg.sv */
// Package: types, codes and sizes shared by the bounded queue block.
`default_nettype none
package bqdp_pkg;
    localparam int QueueDepth   = 16;
    localparam int PayloadBits  = 64;
    localparam int PriorityBits = 3;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_PPUSH  = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_CLOSE  = 3'd4;
    localparam logic [2:0] CMD_REOPEN = 3'd5;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_CLOSED  = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_WAIT    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic [2:0] POL_BLOCK    = 3'd0;
    localparam logic [2:0] POL_OLDEST   = 3'd1;
    localparam logic [2:0] POL_PRIORITY = 3'd2;
    localparam logic [2:0] POL_ADAPTIVE = 3'd3;
    localparam logic [2:0] POL_REJECT   = 3'd4;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_POLICY   = 2'd1;
    localparam logic [1:0] REG_HIGH     = 2'd2;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] payload_in;
        logic [2:0]  event_priority;
        logic [2:0]  request_priority;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] payload_out;
        logic [2:0]  priority_out;
        logic        evicted;
        logic [4:0]  entry_count;
        logic        is_full;
        logic        is_empty;
        logic        is_closed;
        logic [31:0] drop_total;
    } out_item_t;
endpackage
`default_nettype wire

/* src/bqdp_front.sv */
// Front end: takes input items and holds them in a short command queue.
`default_nettype none
module bqdp_front #(
    parameter int CmdDepth = 2
) (
    input  wire  logic              aclk,
    input  wire  logic              aresetn,
    input  wire  logic              s_valid,
    output logic                    s_ready,
    input  wire  bqdp_pkg::in_item_t s_data,
    output logic                    c_valid,
    input  wire  logic              c_ready,
    output bqdp_pkg::in_item_t      c_data
);
    localparam int AW = $clog2(CmdDepth);
    bqdp_pkg::in_item_t mem_reg [CmdDepth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign s_ready = (cnt_reg != (AW+1)'(CmdDepth));
    assign c_valid = (cnt_reg != '0);
    assign c_data  = mem_reg[rd_reg];
    assign push    = s_valid && s_ready;
    assign pop     = c_valid && c_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= s_data;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(CmdDepth-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(CmdDepth-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

/* src/bqdp_back.sv */
// Back end: executes queue commands, scans and compacts for priority eviction.
`default_nettype none
module bqdp_back #(
    parameter int QueueDepth   = bqdp_pkg::QueueDepth,
    parameter int PayloadBits  = bqdp_pkg::PayloadBits,
    parameter int PriorityBits = bqdp_pkg::PriorityBits
) (
    input  wire  logic               aclk,
    input  wire  logic               aresetn,
    input  wire  logic               c_valid,
    output logic                     c_ready,
    input  wire  bqdp_pkg::in_item_t c_data,
    input  wire  logic [4:0]         cap_reg,
    input  wire  logic [2:0]         pol_reg,
    input  wire  logic [2:0]         high_reg,
    output logic                     m_valid,
    input  wire  logic               m_ready,
    output bqdp_pkg::out_item_t      m_data
);
    localparam int AW = $clog2(QueueDepth);
    localparam int CW = AW + 1;

    typedef enum logic [2:0] {IDLE, SCAN, CHECK, SHIFT, SHIFTW, RESULT} state_t;

    logic [PayloadBits-1:0]  pay_mem [QueueDepth];
    logic [PriorityBits-1:0] pri_mem [QueueDepth];

    state_t                  state_reg;
    logic [AW-1:0]           head_reg;
    logic [CW-1:0]           count_reg;
    logic [31:0]             drops_reg;
    logic                    closed_reg;
    bqdp_pkg::in_item_t      cmd_reg;
    logic [CW-1:0]           idx_reg, best_reg;
    logic [PriorityBits-1:0] bestp_reg, rdp_reg;
    logic [PayloadBits-1:0]  rdd_reg;
    logic [2:0]              st_reg;
    logic [63:0]             pout_reg;
    logic [2:0]              prout_reg;
    logic                    ev_reg;
    logic                    out_valid_reg;
    bqdp_pkg::out_item_t     out_reg;

    logic [CW-1:0]           lim;
    logic                    full;
    logic [AW-1:0]           tail_slot, idx_slot, nxt_slot, head_inc;
    logic [PriorityBits-1:0] epri, rpri, rpri_in;
    logic [31:0]             drops_inc;
    logic                    is_push, policy_ok;
    logic [2:0]              pol;

    function automatic logic [AW-1:0] wrap_slot(logic [CW-1:0] s);
        return (s >= CW'(QueueDepth)) ? AW'(s - CW'(QueueDepth)) : AW'(s);
    endfunction

    always_comb begin
        if (cap_reg == 5'd0) begin
            lim = CW'(1);
        end else if (32'(cap_reg) > QueueDepth) begin
            lim = CW'(QueueDepth);
        end else begin
            lim = CW'(cap_reg);
        end
    end

    assign full      = count_reg >= lim;
    assign tail_slot = wrap_slot(CW'(head_reg) + count_reg);
    assign idx_slot  = wrap_slot(CW'(head_reg) + idx_reg);
    assign nxt_slot  = wrap_slot(CW'(head_reg) + idx_reg + CW'(1));
    assign head_inc  = wrap_slot(CW'(head_reg) + CW'(1));
    assign epri      = PriorityBits'(c_data.event_priority);
    assign rpri      = PriorityBits'(cmd_reg.request_priority);
    assign rpri_in   = PriorityBits'(c_data.request_priority);
    assign drops_inc = (drops_reg == '1) ? drops_reg : drops_reg + 1'b1;
    assign is_push   = c_data.command == bqdp_pkg::CMD_PUSH
                    || c_data.command == bqdp_pkg::CMD_PPUSH;
    assign pol       = (pol_reg > bqdp_pkg::POL_REJECT) ? bqdp_pkg::POL_REJECT : pol_reg;
    assign policy_ok = 1'b1;
    assign c_ready   = (state_reg == IDLE) && !(out_valid_reg && !m_ready) && policy_ok;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        rdp_reg <= pri_mem[idx_slot];
        rdd_reg <= pay_mem[nxt_slot];
        if (state_reg == IDLE && c_valid && c_ready && is_push && !closed_reg
            && !full) begin
            pay_mem[tail_slot] <= PayloadBits'(c_data.payload_in);
            pri_mem[tail_slot] <= epri;
        end
        if (state_reg == IDLE && c_valid && c_ready && is_push && !closed_reg
            && full && c_data.command == bqdp_pkg::CMD_PPUSH
            && (pol == bqdp_pkg::POL_OLDEST
                || (pol == bqdp_pkg::POL_ADAPTIVE
                    && rpri_in >= high_reg))) begin
            pay_mem[tail_slot] <= PayloadBits'(c_data.payload_in);
            pri_mem[tail_slot] <= epri;
        end
        if (state_reg == SHIFTW) begin
            pay_mem[idx_slot] <= rdd_reg;
            pri_mem[idx_slot] <= pri_mem[nxt_slot];
        end
        if (state_reg == RESULT) begin
            if (st_reg == bqdp_pkg::ST_DONE && ev_reg
                && cmd_reg.command == bqdp_pkg::CMD_PPUSH
                && pol == bqdp_pkg::POL_PRIORITY) begin
                pay_mem[tail_slot] <= PayloadBits'(cmd_reg.payload_in);
                pri_mem[tail_slot] <= PriorityBits'(cmd_reg.event_priority);
            end
        end
        if (!aresetn) begin
            state_reg     <= IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            drops_reg     <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE: begin
                    if (c_valid && c_ready) begin
                        cmd_reg   <= c_data;
                        st_reg    <= bqdp_pkg::ST_DONE;
                        pout_reg  <= '0;
                        prout_reg <= '0;
                        ev_reg    <= 1'b0;
                        state_reg <= RESULT;
                        case (c_data.command)
                            bqdp_pkg::CMD_PUSH, bqdp_pkg::CMD_PPUSH: begin
                                if (closed_reg) begin
                                    st_reg <= bqdp_pkg::ST_CLOSED;
                                end else if (!full) begin
                                    count_reg <= count_reg + 1'b1;
                                end else if (c_data.command == bqdp_pkg::CMD_PUSH) begin
                                    drops_reg <= drops_inc;
                                    st_reg    <= bqdp_pkg::ST_DROPPED;
                                end else if (pol == bqdp_pkg::POL_BLOCK) begin
                                    st_reg <= bqdp_pkg::ST_WAIT;
                                end else if (pol == bqdp_pkg::POL_OLDEST
                                    || (pol == bqdp_pkg::POL_ADAPTIVE
                                        && rpri_in >= high_reg)) begin
                                    head_reg  <= head_inc;
                                    drops_reg <= drops_inc;
                                    ev_reg    <= 1'b1;
                                end else if (pol == bqdp_pkg::POL_PRIORITY) begin
                                    drops_reg <= drops_inc;
                                    idx_reg   <= '0;
                                    best_reg  <= '0;
                                    state_reg <= SCAN;
                                end else begin
                                    drops_reg <= drops_inc;
                                    st_reg    <= bqdp_pkg::ST_DROPPED;
                                end
                            end
                            bqdp_pkg::CMD_POP: begin
                                if (count_reg == '0) begin
                                    st_reg <= bqdp_pkg::ST_EMPTY;
                                end else begin
                                    pout_reg  <= 64'(pay_mem[head_reg]);
                                    prout_reg <= 3'(pri_mem[head_reg]);
                                    head_reg  <= head_inc;
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            bqdp_pkg::CMD_CLEAR: begin
                                count_reg <= '0;
                                head_reg  <= '0;
                            end
                            bqdp_pkg::CMD_CLOSE:  closed_reg <= 1'b1;
                            bqdp_pkg::CMD_REOPEN: closed_reg <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                SCAN: begin
                    // read of entry idx lands in rdp_reg next cycle
                    state_reg <= CHECK;
                end
                CHECK: begin
                    if (idx_reg == '0 || rdp_reg < bestp_reg) begin
                        best_reg  <= idx_reg;
                        bestp_reg <= rdp_reg;
                    end
                    if (idx_reg + 1'b1 < count_reg) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= SCAN;
                    end else if (((idx_reg == '0 || rdp_reg < bestp_reg) ? rdp_reg
                                  : bestp_reg) >= rpri) begin
                        st_reg    <= bqdp_pkg::ST_DROPPED;
                        state_reg <= RESULT;
                    end else begin
                        ev_reg    <= 1'b1;
                        idx_reg   <= (idx_reg == '0 || rdp_reg < bestp_reg) ? idx_reg
                                     : best_reg;
                        state_reg <= SHIFT;
                    end
                end
                SHIFT: begin
                    if (idx_reg + 1'b1 < count_reg) begin
                        state_reg <= SHIFTW;
                    end else begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= RESULT;
                    end
                end
                SHIFTW: begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= SHIFT;
                end
                RESULT: begin
                    if (ev_reg && cmd_reg.command == bqdp_pkg::CMD_PPUSH
                        && pol == bqdp_pkg::POL_PRIORITY) begin
                        count_reg <= count_reg + 1'b1;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == RESULT) begin
            out_reg.status       <= st_reg;
            out_reg.payload_out  <= pout_reg;
            out_reg.priority_out <= prout_reg;
            out_reg.evicted      <= ev_reg;
            out_reg.entry_count  <= 5'(count_reg + CW'(ev_reg
                && cmd_reg.command == bqdp_pkg::CMD_PPUSH
                && pol == bqdp_pkg::POL_PRIORITY));
            out_reg.is_full      <= (count_reg + CW'(ev_reg
                && cmd_reg.command == bqdp_pkg::CMD_PPUSH
                && pol == bqdp_pkg::POL_PRIORITY)) >= lim;
            out_reg.is_empty     <= (count_reg + CW'(ev_reg
                && cmd_reg.command == bqdp_pkg::CMD_PPUSH
                && pol == bqdp_pkg::POL_PRIORITY)) == '0;
            out_reg.is_closed    <= closed_reg;
            out_reg.drop_total   <= drops_reg;
        end
    end
endmodule
`default_nettype wire

/* src/bounded_queue_with_drop_policy.sv */
// Top level: bounded event queue with a configurable overflow drop policy.
`default_nettype none
// One result item per command. Push, pop, clear, close and reopen pass from
// IDLE to RESULT in the back end; a priority push into a full queue under the
// drop-by-priority policy scans the held entries one by one and then, if a
// victim is chosen, compacts the entries behind it before the result is given.
// A two-entry command queue decouples input acceptance from execution.
module bounded_queue_with_drop_policy #(
    parameter int QUEUE_DEPTH   = bqdp_pkg::QueueDepth,
    parameter int PAYLOAD_BITS  = bqdp_pkg::PayloadBits,
    parameter int PRIORITY_BITS = bqdp_pkg::PriorityBits
) (
    input  wire  logic                aclk,
    input  wire  logic                aresetn,
    input  wire  logic                s_valid,
    output logic                      s_ready,
    input  wire  bqdp_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire  logic                m_ready,
    output bqdp_pkg::out_item_t       m_data,
    input  wire  logic                cfg_valid,
    output logic                      cfg_ready,
    input  wire  logic [1:0]          cfg_index,
    input  wire  logic [31:0]         cfg_data
);
    logic [4:0]         cap_reg;
    logic [2:0]         pol_reg, high_reg;
    logic               c_valid, c_ready;
    bqdp_pkg::in_item_t c_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= 5'd16;
            pol_reg  <= bqdp_pkg::POL_REJECT;
            high_reg <= 3'd2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bqdp_pkg::REG_CAPACITY: cap_reg  <= cfg_data[4:0];
                bqdp_pkg::REG_POLICY:   pol_reg  <= cfg_data[2:0];
                bqdp_pkg::REG_HIGH:     high_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    bqdp_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .c_valid, .c_ready, .c_data
    );

    bqdp_back #(
        .QueueDepth(QUEUE_DEPTH), .PayloadBits(PAYLOAD_BITS),
        .PriorityBits(PRIORITY_BITS)
    ) u_back (
        .aclk, .aresetn, .c_valid, .c_ready, .c_data,
        .cap_reg, .pol_reg, .high_reg,
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the bounded event queue: scoreboard prediction, random traffic and idling.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    class queue_scoreboard;
        logic [63:0] pay_q[$];
        logic [2:0]  pri_q[$];
        logic [31:0] drops;
        bit          closed;
        logic [4:0]  cap_reg;
        logic [2:0]  pol_reg;
        logic [2:0]  high_reg;
        bqdp_pkg::out_item_t pending[$];
        int          errors;

        function new();
            drops = 0;
            closed = 0;
            cap_reg = 5'd16;
            pol_reg = bqdp_pkg::POL_REJECT;
            high_reg = 3'd2;
            errors = 0;
        endfunction

        function int limit();
            int lim;
            lim = cap_reg;
            if (lim < 1) lim = 1;
            if (lim > bqdp_pkg::QueueDepth) lim = bqdp_pkg::QueueDepth;
            return lim;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == bqdp_pkg::REG_CAPACITY) cap_reg = val[4:0];
            else if (idx == bqdp_pkg::REG_POLICY) pol_reg = val[2:0];
            else if (idx == bqdp_pkg::REG_HIGH) high_reg = val[2:0];
        endfunction

        function void bump_drops();
            if (drops != 32'hFFFF_FFFF) drops++;
        endfunction

        function void note_command(bqdp_pkg::in_item_t it);
            bqdp_pkg::out_item_t r;
            bit full;
            int best;
            logic [2:0] pol;
            r = '0;
            r.status = bqdp_pkg::ST_DONE;
            full = pay_q.size() >= limit();
            pol = (pol_reg > bqdp_pkg::POL_REJECT) ? bqdp_pkg::POL_REJECT : pol_reg;
            case (it.command)
                bqdp_pkg::CMD_PUSH, bqdp_pkg::CMD_PPUSH: begin
                    if (closed) begin
                        r.status = bqdp_pkg::ST_CLOSED;
                    end else if (!full) begin
                        pay_q.insert(pay_q.size(), it.payload_in);
                        pri_q.insert(pri_q.size(), it.event_priority);
                    end else if (it.command == bqdp_pkg::CMD_PUSH) begin
                        bump_drops();
                        r.status = bqdp_pkg::ST_DROPPED;
                    end else if (pol == bqdp_pkg::POL_BLOCK) begin
                        r.status = bqdp_pkg::ST_WAIT;
                    end else if (pol == bqdp_pkg::POL_OLDEST ||
                                 (pol == bqdp_pkg::POL_ADAPTIVE &&
                                  it.request_priority >= high_reg)) begin
                        pay_q.delete(0);
                        pri_q.delete(0);
                        bump_drops();
                        r.evicted = 1;
                        pay_q.insert(pay_q.size(), it.payload_in);
                        pri_q.insert(pri_q.size(), it.event_priority);
                    end else if (pol == bqdp_pkg::POL_PRIORITY) begin
                        best = 0;
                        for (int i = 1; i < pri_q.size(); i++)
                            if (pri_q[i] < pri_q[best]) best = i;
                        bump_drops();
                        if (pri_q.size() == 0 || pri_q[best] >= it.request_priority) begin
                            r.status = bqdp_pkg::ST_DROPPED;
                        end else begin
                            pay_q.delete(best);
                            pri_q.delete(best);
                            r.evicted = 1;
                            pay_q.insert(pay_q.size(), it.payload_in);
                            pri_q.insert(pri_q.size(), it.event_priority);
                        end
                    end else begin
                        bump_drops();
                        r.status = bqdp_pkg::ST_DROPPED;
                    end
                end
                bqdp_pkg::CMD_POP: begin
                    if (pay_q.size() == 0) begin
                        r.status = bqdp_pkg::ST_EMPTY;
                    end else begin
                        r.payload_out = pay_q[0];
                        r.priority_out = pri_q[0];
                        pay_q.delete(0);
                        pri_q.delete(0);
                    end
                end
                bqdp_pkg::CMD_CLEAR: begin
                    pay_q.delete();
                    pri_q.delete();
                end
                bqdp_pkg::CMD_CLOSE: closed = 1;
                bqdp_pkg::CMD_REOPEN: closed = 0;
                default: ;
            endcase
            r.entry_count = 5'(pay_q.size());
            r.is_full = pay_q.size() >= limit();
            r.is_empty = pay_q.size() == 0;
            r.is_closed = closed;
            r.drop_total = drops;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(bqdp_pkg::out_item_t got);
            bqdp_pkg::out_item_t w;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            w = pending[0];
            pending.delete(0);
            if (got.status !== w.status) begin
                $error("status exp %0d got %0d", w.status, got.status); errors++;
            end
            if (got.payload_out !== w.payload_out) begin
                $error("payload_out exp %h got %h", w.payload_out, got.payload_out); errors++;
            end
            if (got.priority_out !== w.priority_out) begin
                $error("priority_out exp %0d got %0d", w.priority_out, got.priority_out);
                errors++;
            end
            if (got.evicted !== w.evicted) begin
                $error("evicted exp %0d got %0d", w.evicted, got.evicted); errors++;
            end
            if (got.entry_count !== w.entry_count) begin
                $error("entry_count exp %0d got %0d", w.entry_count, got.entry_count); errors++;
            end
            if (got.is_full !== w.is_full) begin
                $error("is_full exp %0d got %0d", w.is_full, got.is_full); errors++;
            end
            if (got.is_empty !== w.is_empty) begin
                $error("is_empty exp %0d got %0d", w.is_empty, got.is_empty); errors++;
            end
            if (got.is_closed !== w.is_closed) begin
                $error("is_closed exp %0d got %0d", w.is_closed, got.is_closed); errors++;
            end
            if (got.drop_total !== w.drop_total) begin
                $error("drop_total exp %0d got %0d", w.drop_total, got.drop_total); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    bqdp_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    bqdp_pkg::out_item_t m_data;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    queue_scoreboard sb;
    int  cycles = 0;
    int  sink_hold = 0;
    bit  sink_burst = 0;
    bit  gaps_on = 1;

    bounded_queue_with_drop_policy uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver: random stalls, with one long hold-off on request
    initial begin
        int w;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_ready <= 0;
                repeat (sink_hold) @(negedge aclk);
                sink_hold = 0;
            end
            w = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(0, 17) : 0;
            if (w > 0) begin
                m_ready <= 0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_command(bqdp_pkg::in_item_t it);
        int w;
        w = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(0, 17) : 0;
        if (w > 0) begin
            s_valid <= 0;
            repeat (w) @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_command(it);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    function automatic bqdp_pkg::in_item_t make_cmd(logic [2:0] c, logic [2:0] rp);
        bqdp_pkg::in_item_t it;
        it.command = c;
        it.payload_in = {$urandom, $urandom};
        it.event_priority = 3'($urandom_range(0, 7));
        it.request_priority = rp;
        return it;
    endfunction

    task automatic random_phase(int n, int push_bias);
        bqdp_pkg::in_item_t it;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < push_bias)
                it = make_cmd(3'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            else if (r < 90)
                it = make_cmd(bqdp_pkg::CMD_POP, 3'($urandom_range(0, 7)));
            else
                it = make_cmd(3'($urandom_range(3, 7)), 3'($urandom_range(0, 7)));
            if (r >= 90 && it.command == bqdp_pkg::CMD_CLOSE && $urandom_range(0, 1))
                it.command = bqdp_pkg::CMD_REOPEN;
            send_command(it);
        end
    endtask

    initial begin
        bqdp_pkg::in_item_t it;
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: extremes and special cases
        gaps_on = 0;
        it = make_cmd(bqdp_pkg::CMD_POP, 0); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_PUSH, 0); it.payload_in = '1; it.event_priority = 7;
        send_command(it);
        it = make_cmd(bqdp_pkg::CMD_PUSH, 0); it.payload_in = '0; it.event_priority = 0;
        send_command(it);
        it = make_cmd(bqdp_pkg::CMD_POP, 7); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_POP, 7); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_CLOSE, 0); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_PPUSH, 7); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_REOPEN, 0); send_command(it);
        it = make_cmd(3'd6, 0); send_command(it);
        it = make_cmd(3'd7, 0); send_command(it);
        drain();
        write_reg(bqdp_pkg::REG_CAPACITY, 0);
        write_reg(bqdp_pkg::REG_POLICY, bqdp_pkg::POL_BLOCK);
        write_reg(bqdp_pkg::REG_HIGH, 7);
        it = make_cmd(bqdp_pkg::CMD_PUSH, 0); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_PUSH, 0); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_PPUSH, 0); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_CLEAR, 0); send_command(it);
        drain();
        write_reg(bqdp_pkg::REG_CAPACITY, 31);
        write_reg(bqdp_pkg::REG_POLICY, 7);
        for (int k = 0; k < 17; k++) begin
            it = make_cmd(k == 16 ? bqdp_pkg::CMD_PPUSH : bqdp_pkg::CMD_PUSH, 0);
            send_command(it);
        end
        drain();
        // lower the limit below the held count
        write_reg(bqdp_pkg::REG_CAPACITY, 4);
        write_reg(bqdp_pkg::REG_POLICY, bqdp_pkg::POL_PRIORITY);
        it = make_cmd(bqdp_pkg::CMD_PPUSH, 7); send_command(it);
        it = make_cmd(bqdp_pkg::CMD_PPUSH, 0); send_command(it);
        drain();
        gaps_on = 1;

        // random phases over several settings
        for (int ph = 0; ph < 24; ph++) begin
            write_reg(bqdp_pkg::REG_CAPACITY, (ph % 6 == 0) ? 16 : (ph % 6 == 1) ? 1 :
                      $urandom_range(0, 31));
            write_reg(bqdp_pkg::REG_POLICY, ph % 8);
            write_reg(bqdp_pkg::REG_HIGH, $urandom_range(0, 7));
            if (ph == 3) begin
                sink_hold = 300;
                random_phase(40, 95);
            end
            random_phase(66, (ph % 2) ? 70 : 55);
            if (ph % 5 == 4) drain();
            else drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* sim.f */
src/bqdp_pkg.sv
src/bqdp_front.sv
src/bqdp_back.sv
src/bounded_queue_with_drop_policy.sv
tb/tb.sv
